// File: rtl/twd_pkg.sv
// Types and constants shared by the trie word dictionary.
`default_nettype none

package twd_pkg;

	// Operation codes carried in the mode field
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_PREFIX = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int unsigned COUNT_W = 11;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] letter;
		logic       last_letter;
		logic       empty_word;
	} in_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] word_count;
		logic               pool_full;
	} out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LINK,
		ST_MARK
	} state_t;

endpackage

`default_nettype wire

// File: rtl/twd_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module twd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/trie_word_dictionary.sv
// Top level of the trie word dictionary: sequencer, node pool and result register.
`default_nettype none

// Dictionary of words held as a trie in a pool of NODE_COUNT nodes, node 0
// being the root. A word arrives one letter per transaction on the input
// channel and is inserted, searched exactly or searched as a prefix,
// depending on mode; the transaction flagged last_letter yields one result
// transaction carrying found, the word count and pool_full (none in unused
// mode, which only resets the walk). The child links (NODE_COUNT*ALPHABET
// entries) and the word-end marks live in two RAMs with a registered read
// port. After reset a clearing pass zeroes both RAMs, during which no input
// is accepted. Each letter is accepted, then the child-link read that the
// next letter depends on follows. The final letter of a word adds the
// word-end mark read, plus any wait while the result register is occupied.
// Items that do not move the walk (empty items, items after a miss, unused
// mode) skip the link read; a last one but unused mode does the mark read.
// Nodes taken by an insert that ran out of pool stay allocated but unmarked.
module trie_word_dictionary
	import twd_pkg::*;
#(
	parameter int unsigned NODE_COUNT = 1024,
	parameter int unsigned ALPHABET   = 26
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int unsigned LINK_DEPTH = NODE_COUNT * ALPHABET;
	localparam int unsigned SLOT_W     = $clog2(LINK_DEPTH);
	localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
	localparam int unsigned CNT_W      = $clog2(NODE_COUNT + 1);

	// Control state
	state_t              state_q, state_d;
	logic [SLOT_W-1:0]   clr_q, clr_d;      // clearing sweep address
	logic [NODE_W-1:0]   node_q, node_d;    // current node of the walk
	logic [CNT_W-1:0]    free_q, free_d;    // next node to allocate
	logic [CNT_W-1:0]    words_q, words_d;  // distinct words stored
	logic                missed_q, missed_d;
	logic                failed_q, failed_d;
	logic                out_valid_q, out_valid_d;

	// Payload registers
	in_t                 item_q, item_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	out_t                out_q, out_d;

	// RAM ports
	logic                link_we, link_re;
	logic [SLOT_W-1:0]   link_waddr, link_raddr;
	logic [NODE_W-1:0]   link_wdata, link_rdata;
	logic                mark_we, mark_re;
	logic [NODE_W-1:0]   mark_waddr, mark_raddr;
	logic                mark_wdata, mark_rdata;

	// Slot of the incoming letter under the current node
	logic [SLOT_W+4:0]   slot_wide;
	logic [SLOT_W-1:0]   slot_in;
	logic                letter_bad;
	logic [NODE_W-1:0]   nxt_node;
	logic                ok;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign slot_wide = (SLOT_W+5)'(node_q) * (SLOT_W+5)'(ALPHABET)
		+ (SLOT_W+5)'(in_data.letter);
	assign slot_in    = slot_wide[SLOT_W-1:0];
	assign letter_bad = 32'(in_data.letter) >= ALPHABET;

	twd_ram #(
		.WIDTH (NODE_W),
		.DEPTH (LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	twd_ram #(
		.WIDTH (1),
		.DEPTH (NODE_COUNT)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (mark_re),
		.raddr (mark_raddr),
		.rdata (mark_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			free_q      <= CNT_W'(1);
			words_q     <= '0;
			missed_q    <= 1'b0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			node_q      <= node_d;
			free_q      <= free_d;
			words_q     <= words_d;
			missed_q    <= missed_d;
			failed_q    <= failed_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		slot_q <= slot_d;
		out_q  <= out_d;
	end

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		node_d      = node_q;
		free_d      = free_q;
		words_d     = words_q;
		missed_d    = missed_q;
		failed_d    = failed_q;
		out_valid_d = out_valid_q;
		item_d      = item_q;
		slot_d      = slot_q;
		out_d       = out_q;
		link_we     = 1'b0;
		link_waddr  = slot_q;
		link_wdata  = '0;
		link_re     = 1'b0;
		link_raddr  = slot_in;
		mark_we     = 1'b0;
		mark_waddr  = node_q;
		mark_wdata  = 1'b0;
		mark_re     = 1'b0;
		mark_raddr  = node_q;
		nxt_node    = node_q;
		ok          = !missed_q && !failed_q;
		count_ext   = '0;

		// result taken by the consumer
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				// zero the links, and the marks on the first NODE_COUNT addresses
				link_we    = 1'b1;
				link_waddr = clr_q;
				if (32'(clr_q) < NODE_COUNT) begin
					mark_we    = 1'b1;
					mark_waddr = clr_q[NODE_W-1:0];
				end
				if (clr_q == SLOT_W'(LINK_DEPTH - 1))
					state_d = ST_IDLE;
				else
					clr_d = clr_q + SLOT_W'(1);
			end

			ST_IDLE: begin
				if (in_valid) begin
					item_d = in_data;
					slot_d = slot_in;
					if (in_data.mode == MODE_UNUSED) begin
						if (in_data.last_letter) begin
							node_d   = '0;
							missed_d = 1'b0;
							failed_d = 1'b0;
						end
					end else if (!in_data.empty_word && !missed_q && !failed_q
						&& !letter_bad) begin
						link_re = 1'b1;
						state_d = ST_LINK;
					end else begin
						if (!in_data.empty_word && !missed_q && !failed_q)
							missed_d = 1'b1;
						if (in_data.last_letter) begin
							mark_re = 1'b1;
							state_d = ST_MARK;
						end
					end
				end
			end

			ST_LINK: begin
				if (link_rdata == '0) begin
					if (item_q.mode != MODE_INSERT)
						missed_d = 1'b1;
					else if (32'(free_q) >= NODE_COUNT)
						failed_d = 1'b1;
					else begin
						// allocate a fresh node for this slot
						nxt_node   = free_q[NODE_W-1:0];
						free_d     = free_q + CNT_W'(1);
						link_we    = 1'b1;
						link_wdata = free_q[NODE_W-1:0];
					end
				end else begin
					nxt_node = link_rdata;
				end
				node_d = nxt_node;
				if (item_q.last_letter) begin
					mark_re    = 1'b1;
					mark_raddr = nxt_node;
					state_d    = ST_MARK;
				end else begin
					state_d = ST_IDLE;
				end
			end

			ST_MARK: begin
				// mark read data holds while the result register is occupied
				if (!out_valid_q || out_ready) begin
					out_d.found     = 1'b0;
					out_d.pool_full = 1'b0;
					words_d         = words_q;
					unique case (item_q.mode)
						MODE_INSERT: begin
							if (ok) begin
								if (!mark_rdata) begin
									mark_we    = 1'b1;
									mark_wdata = 1'b1;
									words_d    = words_q + CNT_W'(1);
								end
								out_d.found = 1'b1;
							end
							out_d.pool_full = failed_q;
						end
						MODE_SEARCH: out_d.found = ok && mark_rdata;
						default:     out_d.found = ok;
					endcase
					count_ext        = (CNT_W+COUNT_W)'(words_d);
					out_d.word_count = count_ext[COUNT_W-1:0];
					out_valid_d      = 1'b1;
					node_d           = '0;
					missed_d         = 1'b0;
					failed_d         = 1'b0;
					state_d          = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The walk only ever stands on an allocated node.
	a_node_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W+1)'(node_q) < (CNT_W+1)'(free_q))
		else $error("walk on an unallocated node");

	// Each stored word owns a distinct allocated node.
	a_words_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		words_q <= free_q)
		else $error("word count exceeds allocated nodes");

	// A new result only comes out of the mark stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q || out_ready) && out_valid_d |-> state_q == ST_MARK)
		else $error("result produced outside mark stage");

endmodule

`default_nettype wire
